>>> rtl/sfbh_pkg.sv
`timescale 1ns / 1ps
// Package for the byte hash unit: field widths, queue sizing and the
// command word passed from the front end to the mixer. No dependencies.
package sfbh_pkg;

    localparam int WordW     = 32;
    localparam int CountW    = 3;
    localparam int InDataW   = 72;   // 32 + 3 + 32 bits of fields, padded to bytes
    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;    // log2(FifoDepth)
    localparam int FifoCntW  = FifoAw + 1;

    localparam logic [CountW-1:0] FullCount = 3'd4;

    // Mixing operation selected by the front end
    typedef enum logic [2:0] {
        OP_FULL  = 3'd0,   // mix all four bytes
        OP_TAIL1 = 3'd1,   // tail path, one byte
        OP_TAIL2 = 3'd2,   // tail path, two bytes
        OP_TAIL3 = 3'd3,   // tail path, three bytes
        OP_NONE  = 3'd4,   // empty last word, no data mixed
        OP_ZERO  = 3'd5    // zero-length message, result forced to 0
    } op_t;

    typedef struct packed {
        logic             is_last;
        logic             seed_en;
        op_t              op;
        logic [WordW-1:0] seed;
        logic [WordW-1:0] data;
    } cmd_t;

endpackage

>>> rtl/sfbh_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them into mixer commands and
// queues them. Depends on sfbh_pkg.
module sfbh_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sfbh_pkg::WordW-1:0]    data_word,
    input  logic [sfbh_pkg::CountW-1:0]   valid_bytes,
    input  logic                          first_word,
    input  logic                          last_word,
    input  logic [sfbh_pkg::WordW-1:0]    message_length,
    output logic                          cmd_valid,
    input  logic                          cmd_pop,
    output sfbh_pkg::cmd_t                cmd
);

    sfbh_pkg::cmd_t                  fifo_mem [sfbh_pkg::FifoDepth];
    logic [sfbh_pkg::FifoAw-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [sfbh_pkg::FifoAw-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [sfbh_pkg::FifoCntW-1:0]   count_reg, count_next;
    sfbh_pkg::cmd_t                  new_cmd;
    logic                            push;
    logic                            pop;

    // Classification
    always_comb
    begin
        new_cmd.is_last = last_word;
        new_cmd.seed_en = first_word;
        new_cmd.seed    = message_length;
        new_cmd.data    = data_word;
        if (!last_word) begin
            new_cmd.op = sfbh_pkg::OP_FULL;     // count ignored on inner words
        end
        else if (first_word && (message_length == '0)) begin
            new_cmd.op = sfbh_pkg::OP_ZERO;
        end
        else begin
            case (valid_bytes)
                3'd0:    new_cmd.op = sfbh_pkg::OP_NONE;
                3'd1:    new_cmd.op = sfbh_pkg::OP_TAIL1;
                3'd2:    new_cmd.op = sfbh_pkg::OP_TAIL2;
                3'd3:    new_cmd.op = sfbh_pkg::OP_TAIL3;
                default: new_cmd.op = sfbh_pkg::OP_FULL;  // 4 and above
            endcase
        end
    end

    assign in_ready  = (count_reg != sfbh_pkg::FifoCntW'(sfbh_pkg::FifoDepth));
    assign cmd_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    // Queue fill never exceeds its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sfbh_pkg::FifoCntW'(sfbh_pkg::FifoDepth))
        else $error("queue count out of range");

    // Fill level tracks pointer distance
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != sfbh_pkg::FifoCntW'(sfbh_pkg::FifoDepth)) |->
        (sfbh_pkg::FifoAw'(count_reg) == sfbh_pkg::FifoAw'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/sfbh_back.sv
`timescale 1ns / 1ps
// Back end mixer: holds the running hash; folds in one queued word per cycle, a
// last one when the avalanche stage is ready; hands finished pre-avalanche values on. Depends on sfbh_pkg.
module sfbh_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  sfbh_pkg::cmd_t                cmd,
    output logic                          fin_valid,
    input  logic                          fin_ready,
    output logic [sfbh_pkg::WordW-1:0]    fin_hash
);

    logic [sfbh_pkg::WordW-1:0] hash_reg, hash_next;
    logic [sfbh_pkg::WordW-1:0] h_base;
    logic [sfbh_pkg::WordW-1:0] h_mixed;

    function automatic logic [31:0] mix_full(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in + {16'b0, w[15:0]};
        t = ({16'b0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [31:0] mix_tail3(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        h = h_in + {16'b0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ ({24'b0, w[23:16]} << 18);
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [31:0] mix_tail2(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        h = h_in + {16'b0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
        return h;
    endfunction

    function automatic logic [31:0] mix_tail1(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        h = h_in + {24'b0, w[7:0]};
        h = h ^ (h << 10);
        h = h + (h >> 1);
        return h;
    endfunction

    assign h_base = cmd.seed_en ? cmd.seed : hash_reg;

    always_comb
    begin
        case (cmd.op)
            sfbh_pkg::OP_FULL:  h_mixed = mix_full(h_base, cmd.data);
            sfbh_pkg::OP_TAIL1: h_mixed = mix_tail1(h_base, cmd.data);
            sfbh_pkg::OP_TAIL2: h_mixed = mix_tail2(h_base, cmd.data);
            sfbh_pkg::OP_TAIL3: h_mixed = mix_tail3(h_base, cmd.data);
            sfbh_pkg::OP_NONE:  h_mixed = h_base;
            sfbh_pkg::OP_ZERO:  h_mixed = '0;   // avalanche of 0 stays 0
            default:            h_mixed = h_base;
        endcase
    end

    // Inner words never wait; a last word waits for the avalanche stage
    assign cmd_pop   = cmd_valid && (!cmd.is_last || fin_ready);
    assign fin_valid = cmd_valid && cmd.is_last;
    assign fin_hash  = h_mixed;

    always_comb
    begin
        hash_next = hash_reg;
        if (cmd_pop) begin
            hash_next = cmd.is_last ? '0 : h_mixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hash_reg <= '0;
        end
        else begin
            hash_reg <= hash_next;
        end
    end

    // A finished message leaves the running hash at zero
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.is_last) |=> (hash_reg == '0))
        else $error("running hash not cleared after last word");

endmodule

>>> rtl/sfbh_aval.sv
`timescale 1ns / 1ps
// Final avalanche in two pipeline stages; the second stage is the output
// register. Depends on sfbh_pkg.
module sfbh_aval (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fin_valid,
    output logic                          fin_ready,
    input  logic [sfbh_pkg::WordW-1:0]    fin_hash,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sfbh_pkg::WordW-1:0]    hash_value
);

    logic                       s1_valid_reg, s1_valid_next;
    logic [sfbh_pkg::WordW-1:0] s1_hash_reg;
    logic                       s2_valid_reg, s2_valid_next;
    logic [sfbh_pkg::WordW-1:0] s2_hash_reg;
    logic [sfbh_pkg::WordW-1:0] s1_calc;
    logic [sfbh_pkg::WordW-1:0] s2_calc;
    logic                       s2_load;
    logic                       s1_load;

    function automatic logic [31:0] aval_a(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    function automatic logic [31:0] aval_b(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in + (h_in >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    assign s1_calc = aval_a(fin_hash);
    assign s2_calc = aval_b(s1_hash_reg);

    assign s2_load   = !s2_valid_reg || out_ready;
    assign fin_ready = !s1_valid_reg || s2_load;
    assign s1_load   = fin_valid && fin_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (fin_ready) begin
            s1_valid_next = fin_valid;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_load) begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load) begin
            s1_hash_reg <= s1_calc;
        end
        if (s2_load && s1_valid_reg) begin
            s2_hash_reg <= s2_calc;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign hash_value = s2_hash_reg;

    // A stalled first stage keeps its value until the output takes it
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> (s1_valid_reg && $stable(s1_hash_reg)))
        else $error("avalanche stage lost a stalled value");

endmodule

>>> rtl/superfast_byte_hash_unit.sv
`timescale 1ns / 1ps
// Top level of the 32-bit byte hash unit: front end with command queue,
// mixer and avalanche pipeline. Depends on sfbh_pkg, sfbh_front, sfbh_back, sfbh_aval.
//
//  Channel  | Dir | Handshake              | Contents
//  ---------+-----+------------------------+----------------------------------------
//  s_axis   | in  | tvalid/tready          | tdata: data_word, valid_bytes,
//           |     |                        | message_length; tuser: first_word;
//           |     |                        | tlast: last_word
//  m_axis   | out | tvalid/tready          | tdata: hash_value
//
// One word is accepted per cycle while the queue has room; the mixer folds one
// queued word per cycle (a last word waits for the avalanche stage), set by the
// running-hash add/xor loop in the mixer. After its last word is accepted, a
// hash passes through the four-entry queue, where the mixer and the first
// avalanche stage work on it, then the first avalanche register and then the output register.
// A stalled output backs up the avalanche stages and then the queue; words are
// still taken while the queue has room. Reset clears the queue, the running
// hash and the valid flags; no clearing pass is needed.
module superfast_byte_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] data_word, [34:32] valid_bytes, [66:35] message_length, [71:67] zero
    input  logic [sfbh_pkg::InDataW-1:0] s_axis_tdata,
    // [0] first_word
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] hash_value
    output logic [sfbh_pkg::WordW-1:0] m_axis_tdata
);

    sfbh_pkg::cmd_t                cmd;
    logic                          cmd_valid;
    logic                          cmd_pop;
    logic                          fin_valid;
    logic                          fin_ready;
    logic [sfbh_pkg::WordW-1:0]    fin_hash;

    // Front: field unpacking, classification and the command queue
    sfbh_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .data_word      (s_axis_tdata[31:0]),
        .valid_bytes    (s_axis_tdata[34:32]),
        .first_word     (s_axis_tuser),
        .last_word      (s_axis_tlast),
        .message_length (s_axis_tdata[66:35]),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .cmd            (cmd)
    );

    // Back: running hash, full-word and tail mixing
    sfbh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_hash  (fin_hash)
    );

    // Avalanche and output register
    sfbh_aval u_aval (
        .clk        (clk),
        .rst_n      (rst_n),
        .fin_valid  (fin_valid),
        .fin_ready  (fin_ready),
        .fin_hash   (fin_hash),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hash_value (m_axis_tdata)
    );

endmodule

>>> dv/superfast_byte_hash_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for superfast_byte_hash_unit: directed and random
// messages with a built-in hash predictor and random idling on both streams.
// Depends on sfbh_pkg and the superfast_byte_hash_unit RTL.
module superfast_byte_hash_unit_tb;

    localparam int IdlePct    = 37;
    localparam int StallLimit = 1000;   // cycles with no word moving on either side
    localparam int DrainWait  = 10;     // wait after the last predicted hash has been checked
    localparam int RandomNoIdleItems = 300;
    localparam int TotalItems = 950;

    logic                          clk;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // [31:0] data_word, [34:32] valid_bytes, [66:35] message_length, [71:67] zero
    logic [sfbh_pkg::InDataW-1:0]  s_axis_tdata  = '0;
    // [0] first_word
    logic                          s_axis_tuser  = 1'b0;
    logic                          s_axis_tlast  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [31:0] hash_value
    logic [sfbh_pkg::WordW-1:0]    m_axis_tdata;

    bit                            idle_en = 1'b1;
    int unsigned                   words_sent;
    int unsigned                   mismatch_cnt = 0;
    int unsigned                   quiet_cycles = 0;
    logic [sfbh_pkg::WordW-1:0]    hash_state;         // predicted running hash
    logic [sfbh_pkg::WordW-1:0]    pending_hash_q[$];  // hashes still owed by the block

    superfast_byte_hash_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // Full four-byte round: low half added, high half folded in at bit 11.
    function automatic logic [sfbh_pkg::WordW-1:0] fold_word(logic [sfbh_pkg::WordW-1:0] h,
                                                             logic [sfbh_pkg::WordW-1:0] w);
        logic [sfbh_pkg::WordW-1:0] t;
        h = h + {16'h0, w[15:0]};
        t = ({16'h0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    // Partial last word, one to three bytes; bytes are unsigned.
    function automatic logic [sfbh_pkg::WordW-1:0] fold_tail(logic [sfbh_pkg::WordW-1:0] h,
                                                             logic [sfbh_pkg::WordW-1:0] w,
                                                             logic [sfbh_pkg::CountW-1:0] n);
        case (n)
            3'd3:
            begin
                h = h + {16'h0, w[15:0]};
                h = h ^ (h << 16);
                h = h ^ ({24'h0, w[23:16]} << 18);
                h = h + (h >> 11);
            end
            3'd2:
            begin
                h = h + {16'h0, w[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            3'd1:
            begin
                h = h + {24'h0, w[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: ;
        endcase
        return h;
    endfunction

    function automatic logic [sfbh_pkg::WordW-1:0] finish_hash(logic [sfbh_pkg::WordW-1:0] h);
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    // Advance the predicted state by one accepted word; queue a hash on the last.
    function automatic void absorb_word(logic [sfbh_pkg::WordW-1:0] data,
                                        logic [sfbh_pkg::CountW-1:0] count,
                                        logic first, logic last,
                                        logic [sfbh_pkg::WordW-1:0] len);
        logic [sfbh_pkg::CountW-1:0] n;
        logic [sfbh_pkg::WordW-1:0]  h;
        n = (count > sfbh_pkg::FullCount) ? sfbh_pkg::FullCount : count;
        h = first ? len : hash_state;
        if (!last)
        begin
            hash_state = fold_word(h, data);
            return;
        end
        if (first && len == '0)
            pending_hash_q.push_back('0);
        else if (n == sfbh_pkg::FullCount)
            pending_hash_q.push_back(finish_hash(fold_word(h, data)));
        else
            pending_hash_q.push_back(finish_hash(fold_tail(h, data, n)));
        hash_state = '0;
    endfunction

    // ---------------------------------------------------------------- stream drivers

    // Offer one word, with random idle cycles ahead of it; returns at acceptance.
    task automatic send_word(logic [sfbh_pkg::WordW-1:0] data,
                             logic [sfbh_pkg::CountW-1:0] count,
                             logic first, logic last, logic [sfbh_pkg::WordW-1:0] len);
        while (idle_en && $urandom_range(99) < IdlePct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(sfbh_pkg::InDataW - 67){1'b0}}, len, count, data};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_word(data, count, first, last, len);
        words_sent++;
    endtask

    // Output back-pressure
    always @(posedge clk)
        m_axis_tready <= idle_en ? ($urandom_range(99) >= IdlePct) : 1'b1;

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin : check_hash
        logic [sfbh_pkg::WordW-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_hash_q.size() == 0)
            begin
                $error("hash_value: expected none, actual %h", m_axis_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_hash_q.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $error("hash_value: expected %h, actual %h", want, m_axis_tdata);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither stream moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= StallLimit)
            begin
                $display("superfast_byte_hash_unit test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- tests

    // One-word messages with every byte count, including counts above four
    task automatic test_single_word;
        for (int c = 0; c < 8; c++)
            send_word($urandom, c[sfbh_pkg::CountW-1:0], 1'b1, 1'b1, c + 1);
    endtask

    // Zero length forces a zero hash whatever the data and count
    task automatic test_zero_length;
        send_word(32'hFFFF_FFFF, sfbh_pkg::FullCount, 1'b1, 1'b1, 32'h0);
        send_word(32'h0, 3'd7, 1'b1, 1'b1, 32'h0);
    endtask

    // All-ones and all-zeros data and length, and an empty last word
    task automatic test_extremes;
        send_word(32'hFFFF_FFFF, sfbh_pkg::FullCount, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 3'd3, 1'b0, 1'b1, 32'h0);
        send_word(32'h0, sfbh_pkg::FullCount, 1'b1, 1'b0, 32'd4);
        send_word(32'hA5A5_A5A5, 3'd0, 1'b0, 1'b1, 32'hFFFF_FFFF);
    endtask

    // Message without a first flag starts from the zero seed left by the last hash
    task automatic test_no_first_flag;
        send_word($urandom, sfbh_pkg::FullCount, 1'b0, 1'b0, $urandom);
        send_word($urandom, 3'd2, 1'b0, 1'b1, $urandom);
    endtask

    // Count ignored on a middle word; a second first flag re-seeds mid-message
    task automatic test_reseed_mid_message;
        send_word($urandom, sfbh_pkg::FullCount, 1'b1, 1'b0, 32'd13);
        send_word($urandom, 3'd1, 1'b0, 1'b0, $urandom);
        send_word($urandom, 3'd6, 1'b1, 1'b0, $urandom);
        send_word($urandom, 3'd1, 1'b0, 1'b1, $urandom);
    endtask

    // Well-formed message of nbytes bytes with random content and occasional oddities
    task automatic send_message(int unsigned nbytes);
        int unsigned                 nwords;
        int unsigned                 tail;
        logic [sfbh_pkg::WordW-1:0]  len_fld;
        logic [sfbh_pkg::CountW-1:0] cnt;
        logic                        first;
        logic                        last;
        nwords = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
        tail   = nbytes - 4 * (nwords - 1);
        if (tail == 4 && $urandom_range(9) == 0)
        begin
            nwords++;   // trailing empty word
            tail = 0;
        end
        len_fld = ($urandom_range(9) == 0) ? $urandom : nbytes;
        for (int unsigned i = 0; i < nwords; i++)
        begin
            last  = (i == nwords - 1);
            first = (i == 0) && ($urandom_range(19) != 0);
            if (!last)
                cnt = ($urandom_range(19) == 0) ? sfbh_pkg::CountW'($urandom_range(7))
                                                : sfbh_pkg::FullCount;
            else if (tail == 4 && $urandom_range(9) == 0)
                cnt = sfbh_pkg::CountW'($urandom_range(7, 5));
            else
                cnt = sfbh_pkg::CountW'(tail);
            send_word($urandom, cnt, first, last, len_fld);
        end
    endtask

    // Mostly well-formed messages, mostly short; the rest fully random words
    task automatic test_random_messages(int unsigned target);
        int unsigned pick;
        while (words_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_message($urandom_range(16));
            else if (pick < 85)
                send_message($urandom_range(64));
            else if (pick < 87)
                send_message($urandom_range(256));
            else
                send_word($urandom, sfbh_pkg::CountW'($urandom_range(7)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          ($urandom_range(3) == 0) ? 32'h0 : $urandom);
        end
    endtask

    initial
    begin
        hash_state   = '0;
        words_sent   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_word();
        test_zero_length();
        test_extremes();
        test_no_first_flag();
        test_reseed_mid_message();

        idle_en = 1'b0;   // back-to-back stretch on both sides
        test_random_messages(words_sent + RandomNoIdleItems);
        idle_en = 1'b1;
        test_random_messages(TotalItems);
        s_axis_tvalid <= 1'b0;

        while (pending_hash_q.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);

        if (mismatch_cnt == 0 && pending_hash_q.size() == 0)
            $display("superfast_byte_hash_unit test passed");
        else
            $display("superfast_byte_hash_unit test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/sfbh_pkg.sv
rtl/sfbh_front.sv
rtl/sfbh_back.sv
rtl/sfbh_aval.sv
rtl/superfast_byte_hash_unit.sv
dv/superfast_byte_hash_unit_tb.sv
